/* hdl/xmcr_pkg.sv */
// ----------------------------------------------------------------------------
// xmcr_pkg
// Types and constants shared by the XMODEM checksum receiver.
// ----------------------------------------------------------------------------
`default_nettype none

package xmcr_pkg;

    localparam int PACKET_BYTES_DEFAULT = 128;
    localparam int BUF_DEPTH            = 128;
    localparam int BUF_AW               = 7;

    localparam logic [7:0] BYTE_SOH      = 8'h01;
    localparam logic [7:0] BYTE_EOT      = 8'h04;
    localparam logic [7:0] BYTE_CAN      = 8'h18;
    localparam logic [7:0] TIMEOUT_RESET = 8'hFF;
    localparam logic [7:0] COMPL_MATCH   = 8'hFF;

    typedef enum logic [1:0] {
        CMD_BYTE  = 2'd0,
        CMD_TICK  = 2'd1,
        CMD_START = 2'd2,
        CMD_READ  = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        REPLY_NONE = 2'd0,
        REPLY_NAK  = 2'd1,
        REPLY_ACK  = 2'd2
    } reply_t;

    typedef enum logic [2:0] {
        PH_STOPPED    = 3'd0,
        PH_READY      = 3'd1,
        PH_NUMBER     = 3'd2,
        PH_COMPLEMENT = 3'd3,
        PH_DATA       = 3'd4,
        PH_CHECKSUM   = 3'd5,
        PH_ERROR      = 3'd6
    } phase_t;

    typedef struct packed {
        reply_t     reply;
        logic       good;
        logic [7:0] number;
        logic       done;
        phase_t     phase;
    } result_t;

    typedef struct packed {
        logic              en;
        logic [BUF_AW-1:0] addr;
        logic [7:0]        data;
    } mem_wr_t;

endpackage

`default_nettype wire

/* hdl/xmcr_ifs.sv */
// ----------------------------------------------------------------------------
// xmcr interfaces
// Request, result and configuration channels with valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface xmcr_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] command;
    logic [7:0] rx_byte;
    logic [6:0] read_index;

    modport source (output valid, output command, output rx_byte, output read_index,
                    input ready);
    modport sink   (input valid, input command, input rx_byte, input read_index,
                    output ready);
endinterface

interface xmcr_rsp_if;
    logic       valid;
    logic       ready;
    logic [1:0] reply_code;
    logic       packet_good;
    logic [7:0] packet_number;
    logic       transfer_done;
    logic [2:0] receiver_state;
    logic [7:0] read_data;

    modport source (output valid, output reply_code, output packet_good,
                    output packet_number, output transfer_done,
                    output receiver_state, output read_data, input ready);
    modport sink   (input valid, input reply_code, input packet_good,
                    input packet_number, input transfer_done,
                    input receiver_state, input read_data, output ready);
endinterface

interface xmcr_cfg_if;
    logic       valid;
    logic       ready;
    logic [7:0] timeout_limit;

    modport source (output valid, output timeout_limit, input ready);
    modport sink   (input valid, input timeout_limit, output ready);
endinterface

`default_nettype wire

/* hdl/xmodem_checksum_receiver_unit.sv */
// ----------------------------------------------------------------------------
// xmodem_checksum_receiver_unit
// XMODEM receiver, 128-byte packets with 8-bit additive checksum.
// ----------------------------------------------------------------------------
// Usage:
//   req  : one request per event (line byte, timer tick, start, buffer read).
//   rsp  : exactly one result per request, in order: reply code, packet_good
//          and transfer_done pulses, header number, phase, buffer read data.
//   cfg  : writes timeout_limit; always ready, write only while idle.
// Throughput: one request per cycle unless rsp stalls; the state update
//   is a single pass through the control logic between the input and
//   result registers.
// The input register holds one request while a result waits, so one
//   request is still taken when rsp stalls; further requests then stall.
// Reset: phase stopped, counters and sum cleared, timeout_limit 255.
//   The buffer valid bits clear at once, so unwritten entries read zero;
//   no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module xmodem_checksum_receiver_unit #(
    parameter int PACKET_BYTES = xmcr_pkg::PACKET_BYTES_DEFAULT
) (
    input  wire logic clk,
    input  wire logic rst_n,
    xmcr_req_if.sink  req,
    xmcr_rsp_if.source rsp,
    xmcr_cfg_if.sink  cfg
);

    logic              s1_valid_reg;
    logic [1:0]        s1_cmd_reg;
    logic [7:0]        s1_rx_reg;
    logic              accept;
    logic              advance;
    logic              step;
    logic              out_valid;
    logic [7:0]        buf_rdata;
    logic [7:0]        rdata_sel;
    xmcr_pkg::result_t fsm_res;
    xmcr_pkg::result_t out_res;
    xmcr_pkg::mem_wr_t wr;

    assign advance   = !out_valid || rsp.ready;
    assign req.ready = !s1_valid_reg || advance;
    assign accept    = req.valid && req.ready;
    assign step      = s1_valid_reg && advance;
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (step)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_cmd_reg <= req.command;
            s1_rx_reg  <= req.rx_byte;
        end
    end

    xmcr_fsm #(
        .PACKET_BYTES (PACKET_BYTES)
    ) u_fsm (
        .clk      (clk),
        .rst_n    (rst_n),
        .step     (step),
        .command  (s1_cmd_reg),
        .rx_byte  (s1_rx_reg),
        .cfg_we   (cfg.valid),
        .cfg_data (cfg.timeout_limit),
        .result   (fsm_res),
        .wr       (wr)
    );

    xmcr_buf u_buf (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (accept),
        .rd_addr (req.read_index),
        .wr      (wr),
        .rd_data (buf_rdata)
    );

    assign rdata_sel = (s1_cmd_reg == xmcr_pkg::CMD_READ) ? buf_rdata : 8'd0;

    xmcr_hold u_hold (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (step),
        .take      (rsp.ready),
        .res_in    (fsm_res),
        .rdata_in  (rdata_sel),
        .valid     (out_valid),
        .res_out   (out_res),
        .rdata_out (rsp.read_data)
    );

    assign rsp.valid          = out_valid;
    assign rsp.reply_code     = out_res.reply;
    assign rsp.packet_good    = out_res.good;
    assign rsp.packet_number  = out_res.number;
    assign rsp.transfer_done  = out_res.done;
    assign rsp.receiver_state = out_res.phase;

`ifndef SYNTHESIS
    a_hold_stage: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !advance |=> s1_valid_reg)
        else $error("input stage dropped a request under stall");

    a_good_ack: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_res.good |-> out_res.reply == xmcr_pkg::REPLY_ACK)
        else $error("packet_good without ACK");

    a_done_stop: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_res.done |->
            out_res.reply == xmcr_pkg::REPLY_ACK && out_res.phase == xmcr_pkg::PH_STOPPED)
        else $error("transfer_done without ACK and stop");

    a_wr_byte: assert property (@(posedge clk) disable iff (!rst_n)
        step && wr.en |-> s1_cmd_reg == xmcr_pkg::CMD_BYTE)
        else $error("buffer write from a non-byte request");
`endif

endmodule

`default_nettype wire

/* hdl/xmcr_fsm.sv */
// ----------------------------------------------------------------------------
// xmcr_fsm
// Receiver state machine: phase, running sum, header, counters, timeout.
// ----------------------------------------------------------------------------
`default_nettype none

module xmcr_fsm #(
    parameter int PACKET_BYTES = xmcr_pkg::PACKET_BYTES_DEFAULT
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              step,
    input  wire logic [1:0]        command,
    input  wire logic [7:0]        rx_byte,
    input  wire logic              cfg_we,
    input  wire logic [7:0]        cfg_data,
    output xmcr_pkg::result_t      result,
    output xmcr_pkg::mem_wr_t      wr
);

    localparam int CNT_W = $clog2(PACKET_BYTES + 1);

    xmcr_pkg::phase_t phase_reg, phase_next;
    logic [7:0]       sum_reg, sum_next;
    logic [7:0]       hdr_reg, hdr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [7:0]       idle_reg, idle_next;
    logic [7:0]       limit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= xmcr_pkg::PH_STOPPED;
            sum_reg   <= '0;
            hdr_reg   <= '0;
            cnt_reg   <= '0;
            idle_reg  <= '0;
            limit_reg <= xmcr_pkg::TIMEOUT_RESET;
        end
        else
        begin
            if (step)
            begin
                phase_reg <= phase_next;
                sum_reg   <= sum_next;
                hdr_reg   <= hdr_next;
                cnt_reg   <= cnt_next;
                idle_reg  <= idle_next;
            end
            if (cfg_we)
            begin
                limit_reg <= cfg_data;
            end
        end
    end

    always_comb
    begin
        phase_next    = phase_reg;
        sum_next      = sum_reg;
        hdr_next      = hdr_reg;
        cnt_next      = cnt_reg;
        idle_next     = idle_reg;
        result.reply  = xmcr_pkg::REPLY_NONE;
        result.good   = 1'b0;
        result.done   = 1'b0;
        wr.en         = 1'b0;
        wr.addr       = xmcr_pkg::BUF_AW'(cnt_reg);
        wr.data       = rx_byte;

        unique case (xmcr_pkg::cmd_t'(command))
            xmcr_pkg::CMD_BYTE:
            begin
                unique case (phase_reg)
                    xmcr_pkg::PH_READY:
                    begin
                        if (rx_byte == xmcr_pkg::BYTE_SOH)
                        begin
                            phase_next = xmcr_pkg::PH_NUMBER;
                            sum_next   = rx_byte;
                            idle_next  = '0;
                        end
                        else if (rx_byte == xmcr_pkg::BYTE_EOT)
                        begin
                            result.reply = xmcr_pkg::REPLY_ACK;
                            result.done  = 1'b1;
                            phase_next   = xmcr_pkg::PH_STOPPED;
                            idle_next    = '0;
                        end
                        else if (rx_byte == xmcr_pkg::BYTE_CAN)
                        begin
                            phase_next = xmcr_pkg::PH_STOPPED;
                            idle_next  = '0;
                        end
                    end
                    xmcr_pkg::PH_NUMBER:
                    begin
                        hdr_next   = rx_byte;
                        sum_next   = sum_reg + rx_byte;
                        phase_next = xmcr_pkg::PH_COMPLEMENT;
                        idle_next  = '0;
                    end
                    xmcr_pkg::PH_COMPLEMENT:
                    begin
                        if ((hdr_reg ^ rx_byte) == xmcr_pkg::COMPL_MATCH)
                        begin
                            sum_next   = sum_reg + rx_byte;
                            phase_next = xmcr_pkg::PH_DATA;
                            idle_next  = '0;
                            cnt_next   = '0;
                        end
                        else
                        begin
                            phase_next = xmcr_pkg::PH_ERROR;
                        end
                    end
                    xmcr_pkg::PH_DATA:
                    begin
                        idle_next = '0;
                        wr.en     = step;
                        sum_next  = sum_reg + rx_byte;
                        cnt_next  = cnt_reg + CNT_W'(1);
                        if (cnt_next >= CNT_W'(PACKET_BYTES))
                        begin
                            phase_next = xmcr_pkg::PH_CHECKSUM;
                        end
                    end
                    xmcr_pkg::PH_CHECKSUM:
                    begin
                        idle_next = '0;
                        if (rx_byte == sum_reg)
                        begin
                            result.reply = xmcr_pkg::REPLY_ACK;
                            result.good  = 1'b1;
                        end
                        else
                        begin
                            result.reply = xmcr_pkg::REPLY_NAK;
                        end
                        phase_next = xmcr_pkg::PH_READY;
                    end
                    default:
                    begin
                    end
                endcase
            end
            xmcr_pkg::CMD_TICK:
            begin
                if (idle_reg < limit_reg)
                begin
                    idle_next = idle_reg + 8'd1;
                end
                else
                begin
                    phase_next = xmcr_pkg::PH_STOPPED;
                end
            end
            xmcr_pkg::CMD_START:
            begin
                idle_next    = '0;
                hdr_next     = '0;
                phase_next   = xmcr_pkg::PH_READY;
                result.reply = xmcr_pkg::REPLY_NAK;
            end
            default:
            begin
            end
        endcase

        result.number = hdr_next;
        result.phase  = phase_next;
    end

endmodule

`default_nettype wire

/* hdl/xmcr_buf.sv */
// ----------------------------------------------------------------------------
// xmcr_buf
// Packet buffer: registered read, per-entry valid bits, write forwarding.
// ----------------------------------------------------------------------------
`default_nettype none

module xmcr_buf (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        rd_en,
    input  wire logic [xmcr_pkg::BUF_AW-1:0] rd_addr,
    input  wire xmcr_pkg::mem_wr_t           wr,
    output logic [7:0]                       rd_data
);

    logic [7:0]                    mem [xmcr_pkg::BUF_DEPTH];
    logic [xmcr_pkg::BUF_DEPTH-1:0] vld_reg;
    logic [7:0]                    mem_q_reg;
    logic                          vld_q_reg;
    logic                          hit_reg;
    logic [7:0]                    fwd_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (wr.en)
        begin
            vld_reg[wr.addr] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
        if (rd_en)
        begin
            mem_q_reg <= mem[rd_addr];
            vld_q_reg <= vld_reg[rd_addr];
            hit_reg   <= wr.en && (wr.addr == rd_addr);
            fwd_reg   <= wr.data;
        end
    end

    assign rd_data = hit_reg ? fwd_reg : (vld_q_reg ? mem_q_reg : 8'd0);

endmodule

`default_nettype wire

/* hdl/xmcr_ifs_top_note.sv */
// ----------------------------------------------------------------------------
// xmcr_hold
// Output holding register for one result request.
// ----------------------------------------------------------------------------
`default_nettype none

module xmcr_hold (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              load,
    input  wire logic              take,
    input  wire xmcr_pkg::result_t res_in,
    input  wire logic [7:0]        rdata_in,
    output logic                   valid,
    output xmcr_pkg::result_t      res_out,
    output logic [7:0]             rdata_out
);

    logic valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
        end
        else if (take)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_out   <= res_in;
            rdata_out <= rdata_in;
        end
    end

    assign valid = valid_reg;

endmodule

`default_nettype wire
